>>> rtl/pidc_pkg.sv
package pidc_pkg;

  localparam int DATA_W    = 32;
  localparam int INTEG_W   = 48;
  localparam int GAIN_FRAC = 16;
  localparam int DT_FRAC   = 24;
  localparam int QUO_W     = DATA_W + 1 + DT_FRAC;
  localparam int OPA_W     = 64;
  localparam int PROD_W    = 64;
  localparam int ACC_W     = 96;
  localparam int TERM_W    = 62;
  localparam int SUM_W     = 63;
  localparam int CFG_IDX_W = 3;
  localparam int DIV_CNT_W = 6;

  localparam logic [TERM_W-1:0]  TERM_LIMIT  = {2'b01, 60'd0};
  localparam logic [INTEG_W-1:0] INTEG_MAX   = {1'b0, {(INTEG_W-1){1'b1}}};
  localparam logic [INTEG_W-1:0] INTEG_MIN   = {1'b1, {(INTEG_W-1){1'b0}}};
  localparam logic [DATA_W-1:0]  DATA_MAX    = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic [DATA_W-1:0]  DATA_MIN    = {1'b1, {(DATA_W-1){1'b0}}};

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GAIN_P  = 3'd0,
    CFG_GAIN_I  = 3'd1,
    CFG_GAIN_D  = 3'd2,
    CFG_OUT_MAX = 3'd3,
    CFG_OUT_MIN = 3'd4
  } pidc_cfg_idx_t;

  typedef enum logic [1:0] {
    TERM_P,
    TERM_INT,
    TERM_I,
    TERM_D
  } pidc_term_t;

  typedef struct packed {
    logic       capture;
    logic       clear;
    logic       div_start;
    logic       load;
    pidc_term_t sel;
    logic       mul_lo;
    logic       mul_hi;
    logic       mul_acc;
    logic       term_wr;
    logic       sum;
    logic       finish;
  } pidc_cmd_t;

  typedef struct packed {
    logic div_done;
    logic out_free;
  } pidc_status_t;

endpackage

>>> rtl/pidc_ifs.sv
interface pidc_step_if;
  logic                                valid;
  logic                                ready;
  logic                                cmd;
  logic signed [pidc_pkg::DATA_W-1:0]  target;
  logic signed [pidc_pkg::DATA_W-1:0]  measured;
  logic        [pidc_pkg::DATA_W-1:0]  time_step;

  modport source (output valid, cmd, target, measured, time_step, input ready);
  modport sink   (input valid, cmd, target, measured, time_step, output ready);
endinterface

interface pidc_result_if;
  logic                               valid;
  logic                               ready;
  logic signed [pidc_pkg::DATA_W-1:0] drive;

  modport source (output valid, drive, input ready);
  modport sink   (input valid, drive, output ready);
endinterface

interface pidc_cfg_if;
  logic                               valid;
  logic                               ready;
  logic [pidc_pkg::CFG_IDX_W-1:0]     index;
  logic [pidc_pkg::DATA_W-1:0]        data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

>>> rtl/pidc_div.sv
module pidc_div (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [pidc_pkg::QUO_W-1:0]    numer,
  input  logic [pidc_pkg::DATA_W-1:0]   denom,
  output logic                          done,
  output logic [pidc_pkg::QUO_W-1:0]    quo
);

  logic                              busy;
  logic [pidc_pkg::DIV_CNT_W-1:0]    cnt;
  logic [pidc_pkg::QUO_W-1:0]        nq;
  logic [pidc_pkg::DATA_W-1:0]       rem;
  logic [pidc_pkg::DATA_W:0]         rem_sh;
  logic [pidc_pkg::DATA_W:0]         rem_sub;
  logic                              ge;

  assign rem_sh  = {rem, nq[pidc_pkg::QUO_W-1]};
  assign rem_sub = rem_sh - {1'b0, denom};
  assign ge      = rem_sh >= {1'b0, denom};
  assign done    = !busy;
  assign quo     = nq;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= pidc_pkg::DIV_CNT_W'(pidc_pkg::QUO_W - 1);
    end else if (busy) begin
      cnt <= cnt - 1'b1;
      if (cnt == '0) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      nq  <= numer;
      rem <= '0;
    end else if (busy) begin
      nq  <= {nq[pidc_pkg::QUO_W-2:0], ge};
      rem <= ge ? rem_sub[pidc_pkg::DATA_W-1:0] : rem_sh[pidc_pkg::DATA_W-1:0];
    end
  end

endmodule

>>> rtl/pidc_datapath.sv
module pidc_datapath (
  input  logic                               clk,
  input  logic                               rst,
  input  pidc_pkg::pidc_cmd_t                ctl,
  output pidc_pkg::pidc_status_t             stat,
  input  logic signed [pidc_pkg::DATA_W-1:0] target,
  input  logic signed [pidc_pkg::DATA_W-1:0] measured,
  input  logic        [pidc_pkg::DATA_W-1:0] time_step,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [pidc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [pidc_pkg::DATA_W-1:0]        cfg_data,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic signed [pidc_pkg::DATA_W-1:0] drive
);

  function automatic logic [pidc_pkg::DATA_W-1:0] mag32(logic [pidc_pkg::DATA_W-1:0] a);
    return a[pidc_pkg::DATA_W-1] ? (~a + 1'b1) : a;
  endfunction

  function automatic logic [pidc_pkg::INTEG_W-1:0] mag48(logic [pidc_pkg::INTEG_W-1:0] a);
    return a[pidc_pkg::INTEG_W-1] ? (~a + 1'b1) : a;
  endfunction

  logic signed [pidc_pkg::DATA_W-1:0]  gain_p;
  logic signed [pidc_pkg::DATA_W-1:0]  gain_i;
  logic signed [pidc_pkg::DATA_W-1:0]  gain_d;
  logic signed [pidc_pkg::DATA_W-1:0]  out_max;
  logic signed [pidc_pkg::DATA_W-1:0]  out_min;

  logic signed [pidc_pkg::INTEG_W-1:0] integ;
  logic signed [pidc_pkg::DATA_W-1:0]  last_err;
  logic signed [pidc_pkg::DATA_W-1:0]  err;
  logic        [pidc_pkg::DATA_W-1:0]  dt;
  logic                                diff_neg;

  logic [pidc_pkg::OPA_W-1:0]          op_a;
  logic [pidc_pkg::DATA_W-1:0]         op_b;
  logic                                sh24;
  logic                                neg;
  logic [pidc_pkg::PROD_W-1:0]         prod;
  logic [pidc_pkg::ACC_W-1:0]          acc;

  logic signed [pidc_pkg::TERM_W-1:0]  pterm;
  logic signed [pidc_pkg::TERM_W-1:0]  iterm;
  logic signed [pidc_pkg::TERM_W-1:0]  dterm;
  logic signed [pidc_pkg::SUM_W-1:0]   res;

  logic [pidc_pkg::DATA_W:0]           d_in;
  logic [pidc_pkg::DATA_W-1:0]         err_next;
  logic [pidc_pkg::DATA_W:0]           d_err;
  logic [pidc_pkg::DATA_W:0]           d_mag;
  logic                                div_done;
  logic [pidc_pkg::QUO_W-1:0]          quo;

  logic [pidc_pkg::ACC_W-1:0]          shifted;
  logic [pidc_pkg::TERM_W-1:0]         tmag;
  logic [pidc_pkg::TERM_W-1:0]         tval;
  logic [pidc_pkg::TERM_W-1:0]         isum;
  logic [pidc_pkg::INTEG_W-1:0]        integ_next;
  logic signed [pidc_pkg::SUM_W-1:0]   hi_lim;
  logic signed [pidc_pkg::SUM_W-1:0]   lo_lim;
  logic signed [pidc_pkg::DATA_W-1:0]  drive_next;

  assign cfg_ready     = 1'b1;
  assign stat.div_done = div_done;
  assign stat.out_free = !out_valid || out_ready;

  assign d_in = {target[pidc_pkg::DATA_W-1], target} - {measured[pidc_pkg::DATA_W-1], measured};

  always_comb begin
    if (d_in[pidc_pkg::DATA_W] != d_in[pidc_pkg::DATA_W-1]) begin
      err_next = d_in[pidc_pkg::DATA_W] ? pidc_pkg::DATA_MIN : pidc_pkg::DATA_MAX;
    end else begin
      err_next = d_in[pidc_pkg::DATA_W-1:0];
    end
  end

  assign d_err = {err[pidc_pkg::DATA_W-1], err} - {last_err[pidc_pkg::DATA_W-1], last_err};
  assign d_mag = d_err[pidc_pkg::DATA_W] ? (~d_err + 1'b1) : d_err;

  pidc_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (ctl.div_start),
    .numer ({d_mag, {pidc_pkg::DT_FRAC{1'b0}}}),
    .denom (dt),
    .done  (div_done),
    .quo   (quo)
  );

  assign shifted = sh24 ? (acc >> pidc_pkg::DT_FRAC) : (acc >> pidc_pkg::GAIN_FRAC);
  assign tmag    = (shifted > pidc_pkg::ACC_W'(pidc_pkg::TERM_LIMIT)) ?
                   pidc_pkg::TERM_LIMIT : shifted[pidc_pkg::TERM_W-1:0];
  assign tval    = neg ? (~tmag + 1'b1) : tmag;
  assign isum    = {{(pidc_pkg::TERM_W-pidc_pkg::INTEG_W){integ[pidc_pkg::INTEG_W-1]}}, integ}
                   + tval;

  always_comb begin
    if ((&isum[pidc_pkg::TERM_W-1:pidc_pkg::INTEG_W-1]) ||
        !(|isum[pidc_pkg::TERM_W-1:pidc_pkg::INTEG_W-1])) begin
      integ_next = isum[pidc_pkg::INTEG_W-1:0];
    end else begin
      integ_next = isum[pidc_pkg::TERM_W-1] ? pidc_pkg::INTEG_MIN : pidc_pkg::INTEG_MAX;
    end
  end

  assign hi_lim = {{(pidc_pkg::SUM_W-pidc_pkg::DATA_W){out_max[pidc_pkg::DATA_W-1]}}, out_max};
  assign lo_lim = {{(pidc_pkg::SUM_W-pidc_pkg::DATA_W){out_min[pidc_pkg::DATA_W-1]}}, out_min};

  always_comb begin
    priority if (res > hi_lim) begin
      drive_next = out_max;
    end else if (res < lo_lim) begin
      drive_next = out_min;
    end else begin
      drive_next = res[pidc_pkg::DATA_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      gain_p    <= '0;
      gain_i    <= '0;
      gain_d    <= '0;
      out_max   <= pidc_pkg::DATA_MAX;
      out_min   <= pidc_pkg::DATA_MIN;
      integ     <= '0;
      last_err  <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          pidc_pkg::CFG_GAIN_P:  gain_p  <= cfg_data;
          pidc_pkg::CFG_GAIN_I:  gain_i  <= cfg_data;
          pidc_pkg::CFG_GAIN_D:  gain_d  <= cfg_data;
          pidc_pkg::CFG_OUT_MAX: out_max <= cfg_data;
          pidc_pkg::CFG_OUT_MIN: out_min <= cfg_data;
          default: ;
        endcase
      end
      if (ctl.clear) begin
        integ    <= '0;
        last_err <= '0;
      end
      if (ctl.term_wr && ctl.sel == pidc_pkg::TERM_INT) begin
        integ <= integ_next;
      end
      if (ctl.finish) begin
        last_err  <= err;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      err <= err_next;
      dt  <= time_step;
    end
    if (ctl.div_start) begin
      diff_neg <= d_err[pidc_pkg::DATA_W];
    end
    if (ctl.load) begin
      unique case (ctl.sel)
        pidc_pkg::TERM_P: begin
          op_a <= pidc_pkg::OPA_W'(mag32(err));
          op_b <= mag32(gain_p);
          sh24 <= 1'b0;
          neg  <= err[pidc_pkg::DATA_W-1] ^ gain_p[pidc_pkg::DATA_W-1];
        end
        pidc_pkg::TERM_INT: begin
          op_a <= pidc_pkg::OPA_W'(mag32(err));
          op_b <= dt;
          sh24 <= 1'b1;
          neg  <= err[pidc_pkg::DATA_W-1];
        end
        pidc_pkg::TERM_I: begin
          op_a <= pidc_pkg::OPA_W'(mag48(integ));
          op_b <= mag32(gain_i);
          sh24 <= 1'b0;
          neg  <= integ[pidc_pkg::INTEG_W-1] ^ gain_i[pidc_pkg::DATA_W-1];
        end
        pidc_pkg::TERM_D: begin
          op_a <= (dt == '0) ? '0 : pidc_pkg::OPA_W'(quo);
          op_b <= mag32(gain_d);
          sh24 <= 1'b0;
          neg  <= diff_neg ^ gain_d[pidc_pkg::DATA_W-1];
        end
        default: ;
      endcase
    end
    if (ctl.mul_lo) begin
      prod <= op_a[pidc_pkg::DATA_W-1:0] * op_b;
      acc  <= '0;
    end
    if (ctl.mul_hi) begin
      prod <= op_a[pidc_pkg::OPA_W-1:pidc_pkg::DATA_W] * op_b;
      acc  <= acc + pidc_pkg::ACC_W'(prod);
    end
    if (ctl.mul_acc) begin
      acc <= acc + {prod, {pidc_pkg::DATA_W{1'b0}}};
    end
    if (ctl.term_wr) begin
      unique case (ctl.sel)
        pidc_pkg::TERM_P: pterm <= tval;
        pidc_pkg::TERM_I: iterm <= tval;
        pidc_pkg::TERM_D: dterm <= tval;
        default: ;
      endcase
    end
    if (ctl.sum) begin
      res <= {pterm[pidc_pkg::TERM_W-1], pterm}
           + {iterm[pidc_pkg::TERM_W-1], iterm}
           + {dterm[pidc_pkg::TERM_W-1], dterm};
    end
    if (ctl.finish) begin
      drive <= drive_next;
    end
  end

endmodule

>>> rtl/pidc_ctrl.sv
module pidc_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   step_valid,
  input  logic                   step_cmd,
  output logic                   step_ready,
  output pidc_pkg::pidc_cmd_t    ctl,
  input  pidc_pkg::pidc_status_t stat
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_START,
    ST_LOAD,
    ST_MLO,
    ST_MHI,
    ST_MACC,
    ST_MEND,
    ST_WAIT_DIV,
    ST_SUM,
    ST_OUT
  } state_t;

  state_t               state;
  pidc_pkg::pidc_term_t sel;

  assign step_ready = (state == ST_IDLE);

  always_comb begin
    ctl           = '0;
    ctl.sel       = sel;
    ctl.capture   = (state == ST_IDLE) && step_valid && !step_cmd;
    ctl.clear     = (state == ST_IDLE) && step_valid && step_cmd;
    ctl.div_start = (state == ST_START);
    ctl.load      = (state == ST_LOAD);
    ctl.mul_lo    = (state == ST_MLO);
    ctl.mul_hi    = (state == ST_MHI);
    ctl.mul_acc   = (state == ST_MACC);
    ctl.term_wr   = (state == ST_MEND);
    ctl.sum       = (state == ST_SUM);
    ctl.finish    = (state == ST_OUT) && stat.out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      sel   <= pidc_pkg::TERM_P;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (step_valid && !step_cmd) begin
            state <= ST_START;
          end
        end
        ST_START: begin
          sel   <= pidc_pkg::TERM_P;
          state <= ST_LOAD;
        end
        ST_LOAD: state <= ST_MLO;
        ST_MLO:  state <= ST_MHI;
        ST_MHI:  state <= ST_MACC;
        ST_MACC: state <= ST_MEND;
        ST_MEND: begin
          unique case (sel)
            pidc_pkg::TERM_P: begin
              sel   <= pidc_pkg::TERM_INT;
              state <= ST_LOAD;
            end
            pidc_pkg::TERM_INT: begin
              sel   <= pidc_pkg::TERM_I;
              state <= ST_LOAD;
            end
            pidc_pkg::TERM_I: begin
              sel   <= pidc_pkg::TERM_D;
              state <= ST_WAIT_DIV;
            end
            pidc_pkg::TERM_D: state <= ST_SUM;
            default: state <= ST_IDLE;
          endcase
        end
        ST_WAIT_DIV: begin
          if (stat.div_done) begin
            state <= ST_LOAD;
          end
        end
        ST_SUM: state <= ST_OUT;
        ST_OUT: begin
          if (stat.out_free) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  a_finish_free: assert property (@(posedge clk) disable iff (rst)
    ctl.finish |-> stat.out_free)
    else $error("result written while output register held");

  a_dterm_after_div: assert property (@(posedge clk) disable iff (rst)
    (ctl.load && ctl.sel == pidc_pkg::TERM_D) |-> stat.div_done)
    else $error("derivative operands loaded before quotient ready");

  a_ready_after_finish: assert property (@(posedge clk) disable iff (rst)
    ctl.finish |=> step_ready)
    else $error("not ready after result");

  a_one_command: assert property (@(posedge clk) disable iff (rst)
    $onehot0({ctl.capture, ctl.clear, ctl.div_start, ctl.load, ctl.mul_lo,
              ctl.mul_hi, ctl.mul_acc, ctl.term_wr, ctl.sum, ctl.finish}))
    else $error("overlapping datapath commands");

endmodule

>>> rtl/pid_controller_clamped_top.sv
// PID controller with output clamp, Q16.16 signals and gains, Q8.24 time step.
// Channels: step (sink) takes a request with cmd, target, measured, time_step;
// result (source) returns drive; cfg (sink) writes gain_p, gain_i, gain_d,
// out_max, out_min at indexes 0 to 4 and is always ready.
// A compute request (cmd 0) gives one result. Step takes the next request on the
// cycle after the result is written, so requests do not overlap; the 57-step
// serial divider for the derivative takes most of the time of a request, while
// the first three of the four scaled products run on one shared 32x32 multiplier
// in its shadow.
// A clear request (cmd 1) zeroes the integral and the previous error, and gives
// no result.
// Reset clears the integral, the previous error and the gains, opens the
// clamp to the full range, and empties the output register.
// A finished result waits in the output register while result.ready is low;
// step stays ready for the next request, which runs until its own result
// must be written, and then holds until the register is taken.
// Write cfg only while no request is in flight.
module pid_controller_clamped_top (
  input  logic          clk,
  input  logic          rst,
  pidc_step_if.sink     step,
  pidc_result_if.source result,
  pidc_cfg_if.sink      cfg
);

  pidc_pkg::pidc_cmd_t    ctl;
  pidc_pkg::pidc_status_t stat;

  pidc_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .step_valid (step.valid),
    .step_cmd   (step.cmd),
    .step_ready (step.ready),
    .ctl        (ctl),
    .stat       (stat)
  );

  pidc_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .ctl       (ctl),
    .stat      (stat),
    .target    (step.target),
    .measured  (step.measured),
    .time_step (step.time_step),
    .cfg_valid (cfg.valid),
    .cfg_ready (cfg.ready),
    .cfg_index (cfg.index),
    .cfg_data  (cfg.data),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .drive     (result.drive)
  );

endmodule

>>> tb/sv/pidc_tb_pkg.sv
package pidc_tb_pkg;

  localparam logic CMD_STEP  = 1'b0;
  localparam logic CMD_CLEAR = 1'b1;

endpackage

>>> tb/sv/pidc_drive_checker.sv
module pidc_drive_checker (
  input  logic   clk,
  input  logic   rst,
  pidc_step_if   step,
  pidc_result_if result,
  pidc_cfg_if    cfg,
  output int     mismatches,
  output int     pending
);
  timeunit 1ns;
  timeprecision 1ps;

  import pidc_pkg::*;
  import pidc_tb_pkg::*;

  localparam logic [63:0] TERM_CAP = 64'(TERM_LIMIT);
  localparam longint ERR_HI   = longint'($signed(DATA_MAX));
  localparam longint ERR_LO   = longint'($signed(DATA_MIN));
  localparam longint INTEG_HI = longint'($signed(INTEG_MAX));
  localparam longint INTEG_LO = longint'($signed(INTEG_MIN));

  logic signed [DATA_W-1:0]  kp, ki, kd, hi_lim, lo_lim, prev_err;
  logic signed [INTEG_W-1:0] integ;
  logic signed [DATA_W-1:0]  predicted_drive [$];
  logic signed [DATA_W-1:0]  want;
  int                        miss_cnt = 0;

  function automatic logic [63:0] magn(input longint a);
    return (a < 0) ? 64'(-a) : 64'(a);
  endfunction

  function automatic longint scaled(input longint a, input longint b, input int sh);
    logic [127:0] full;
    logic [63:0]  r;
    full = {64'd0, magn(a)} * {64'd0, magn(b)};
    full = full >> sh;
    r = (full > {64'd0, TERM_CAP}) ? TERM_CAP : full[63:0];
    return ((a < 0) != (b < 0)) ? -longint'(r) : longint'(r);
  endfunction

  function automatic logic signed [DATA_W-1:0] advance_loop(
    input logic signed [DATA_W-1:0] sp,
    input logic signed [DATA_W-1:0] pv,
    input logic        [DATA_W-1:0] dt
  );
    longint      err, acc, p_term, i_term, d_term, diff, q, res;
    logic [63:0] slope;
    err = longint'(sp) - longint'(pv);
    if (err > ERR_HI) err = ERR_HI;
    if (err < ERR_LO) err = ERR_LO;
    p_term = scaled(err, longint'(kp), GAIN_FRAC);
    acc = longint'(integ) + scaled(err, longint'({32'd0, dt}), DT_FRAC);
    if (acc > INTEG_HI) acc = INTEG_HI;
    if (acc < INTEG_LO) acc = INTEG_LO;
    integ = acc[INTEG_W-1:0];
    i_term = scaled(longint'(integ), longint'(ki), GAIN_FRAC);
    d_term = 0;
    if (dt != '0) begin
      diff = err - longint'(prev_err);
      slope = (magn(diff) << DT_FRAC) / {32'd0, dt};
      q = (diff < 0) ? -longint'(slope) : longint'(slope);
      d_term = scaled(q, longint'(kd), GAIN_FRAC);
    end
    res = p_term + i_term + d_term;
    if (res > longint'(hi_lim)) res = longint'(hi_lim);
    else if (res < longint'(lo_lim)) res = longint'(lo_lim);
    prev_err = err[DATA_W-1:0];
    return res[DATA_W-1:0];
  endfunction

  task automatic report(input string what, input logic [DATA_W-1:0] got,
                        input logic [DATA_W-1:0] want_v);
    $display("%0t: %s: drive %h, predicted %h", $time, what, got, want_v);
    miss_cnt++;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      kp = '0;
      ki = '0;
      kd = '0;
      hi_lim = DATA_MAX;
      lo_lim = DATA_MIN;
      integ = '0;
      prev_err = '0;
      predicted_drive.delete();
    end else begin
      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          CFG_GAIN_P:  kp = cfg.data;
          CFG_GAIN_I:  ki = cfg.data;
          CFG_GAIN_D:  kd = cfg.data;
          CFG_OUT_MAX: hi_lim = cfg.data;
          CFG_OUT_MIN: lo_lim = cfg.data;
          default: ;
        endcase
      end
      if (result.valid && result.ready) begin
        if (predicted_drive.size() == 0) begin
          report("unexpected result", result.drive, '0);
        end else begin
          want = predicted_drive.pop_front();
          if (result.drive !== want) report("drive mismatch", result.drive, want);
        end
      end
      if (step.valid && step.ready) begin
        if (step.cmd == CMD_CLEAR) begin
          integ = '0;
          prev_err = '0;
        end else begin
          predicted_drive.push_back(advance_loop(step.target, step.measured, step.time_step));
        end
      end
    end
    mismatches <= miss_cnt;
    pending <= predicted_drive.size();
  end

endmodule

>>> tb/sv/pid_controller_clamped_top_tb.sv
module pid_controller_clamped_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import pidc_pkg::*;
  import pidc_tb_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int HOLD_OFF       = 3000;
  localparam int SETTLE         = 80;
  localparam int PHASES         = 8;
  localparam int PHASE_ITEMS    = 170;
  localparam int WINDUP_ITEMS   = 270;

  typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;

  logic clk  = 1'b0;
  logic rst  = 1'b1;
  logic take = 1'b0;
  int   send_idle_pct  = 0;
  int   recv_stall_pct = 0;
  int   hold_token = 0;
  int   hold_seen  = 0;
  int   hold_left  = 0;
  int   mismatches;
  int   pending;

  pidc_step_if   step_if ();
  pidc_result_if result_if ();
  pidc_cfg_if    cfg_if ();

  pid_controller_clamped_top uut (
    .clk   (clk),
    .rst   (rst),
    .step  (step_if),
    .result(result_if),
    .cfg   (cfg_if)
  );

  pidc_drive_checker drive_chk (
    .clk       (clk),
    .rst       (rst),
    .step      (step_if),
    .result    (result_if),
    .cfg       (cfg_if),
    .mismatches(mismatches),
    .pending   (pending)
  );

  assign result_if.ready = take;

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (hold_seen != hold_token) begin
      hold_seen <= hold_token;
      hold_left <= HOLD_OFF;
      take <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      take <= 1'b0;
    end else begin
      take <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (rst || (step_if.valid && step_if.ready) || (result_if.valid && result_if.ready) ||
          (cfg_if.valid && cfg_if.ready)) quiet = 0;
      else quiet++;
    end
    $display("pid_controller_clamped_top_tb: FAIL");
    $finish;
  end

  task automatic set_idling(input idle_mode_t mode);
    case (mode)
      IDLE_NONE: begin
        send_idle_pct = 0;
        recv_stall_pct <= 0;
      end
      IDLE_SEND: begin
        send_idle_pct = 73;
        recv_stall_pct <= 0;
      end
      IDLE_RECV: begin
        send_idle_pct = 0;
        recv_stall_pct <= 73;
      end
      default: begin
        send_idle_pct = 13;
        recv_stall_pct <= 13;
      end
    endcase
  endtask

  task automatic load_config(input logic [DATA_W-1:0] p_gain, i_gain, d_gain, hi, lo);
    logic [DATA_W-1:0] vals [5];
    pidc_cfg_idx_t     order [5];
    vals  = '{p_gain, i_gain, d_gain, hi, lo};
    order = '{CFG_GAIN_P, CFG_GAIN_I, CFG_GAIN_D, CFG_OUT_MAX, CFG_OUT_MIN};
    for (int i = 0; i < 5; i++) begin
      cfg_if.valid <= 1'b1;
      cfg_if.index <= order[i];
      cfg_if.data <= vals[i];
      do @(posedge clk); while (!cfg_if.ready);
    end
    cfg_if.valid <= 1'b0;
  endtask

  task automatic send_item(input logic c, input logic [DATA_W-1:0] sp, pv, dt);
    while ($urandom_range(99) < send_idle_pct) begin
      step_if.valid <= 1'b0;
      @(posedge clk);
    end
    step_if.valid <= 1'b1;
    step_if.cmd <= c;
    step_if.target <= sp;
    step_if.measured <= pv;
    step_if.time_step <= dt;
    do @(posedge clk); while (!step_if.ready);
  endtask

  task automatic drain();
    step_if.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  function automatic logic [DATA_W-1:0] pick_gain(input int kind);
    logic [DATA_W-1:0] g;
    case (kind)
      0: g = 32'($urandom_range(32'h0004_0000));
      1: g = $urandom_range(1) ? DATA_MAX : DATA_MIN;
      2: g = $urandom();
      default: g = 32'($urandom_range(32'h0000_0400));
    endcase
    if (kind != 1 && $urandom_range(1)) g = -g;
    return g;
  endfunction

  function automatic logic [DATA_W-1:0] pick_signal();
    logic [DATA_W-1:0] v;
    int                r;
    r = $urandom_range(9);
    if (r < 4) begin
      v = 32'($urandom_range(32'h0004_0000));
      if ($urandom_range(1)) v = -v;
    end else if (r < 7) begin
      v = $urandom();
    end else begin
      case ($urandom_range(4))
        0: v = DATA_MAX;
        1: v = DATA_MIN;
        2: v = '0;
        3: v = 32'd1;
        default: v = '1;
      endcase
    end
    return v;
  endfunction

  function automatic logic [DATA_W-1:0] pick_dt();
    logic [DATA_W-1:0] dt;
    case ($urandom_range(9))
      0: dt = '0;
      1: dt = 32'($urandom_range(255, 1));
      2: dt = $urandom();
      3: dt = '1;
      default: dt = 32'($urandom_range(32'h0100_0000, 32'h0000_1000));
    endcase
    return dt;
  endfunction

  task automatic send_random();
    logic [DATA_W-1:0] sp, pv;
    sp = pick_signal();
    if ($urandom_range(9) < 3) pv = sp + 32'($urandom_range(32'h0000_2000)) - 32'h0000_1000;
    else pv = pick_signal();
    send_item(($urandom_range(99) < 7) ? CMD_CLEAR : CMD_STEP, sp, pv, pick_dt());
  endtask

  task automatic phase_config(input int p);
    logic [DATA_W-1:0] hi, lo;
    int                kind;
    kind = p % 4;
    case (p % 3)
      0: begin
        hi = DATA_MAX;
        lo = DATA_MIN;
      end
      1: begin
        hi = 32'($urandom_range(32'h0020_0000));
        lo = -32'($urandom_range(32'h0020_0000));
      end
      default: begin
        hi = $urandom();
        lo = $urandom();
      end
    endcase
    if (p == PHASES - 1) begin
      hi = DATA_MIN;
      lo = DATA_MAX;
    end
    load_config(pick_gain(kind), pick_gain(kind), pick_gain(kind), hi, lo);
  endtask

  initial begin
    step_if.valid = 1'b0;
    step_if.cmd = CMD_STEP;
    step_if.target = '0;
    step_if.measured = '0;
    step_if.time_step = '0;
    cfg_if.valid = 1'b0;
    cfg_if.index = CFG_GAIN_P;
    cfg_if.data = '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    set_idling(IDLE_NONE);

    load_config(32'h0001_0000, 32'h0000_8000, 32'h0000_4000, DATA_MAX, DATA_MIN);
    send_item(CMD_STEP, '0, '0, '0);
    send_item(CMD_STEP, DATA_MAX, DATA_MIN, 32'h0100_0000);
    send_item(CMD_STEP, DATA_MIN, DATA_MAX, 32'h0100_0000);
    send_item(CMD_STEP, 32'h0001_0000, '0, '0);
    send_item(CMD_STEP, 32'h0002_0000, 32'h0001_0000, '1);
    send_item(CMD_STEP, 32'h0001_0000, '0, 32'd1);
    send_item(CMD_CLEAR, $urandom(), $urandom(), $urandom());
    send_item(CMD_STEP, 32'h0000_8000, '0, 32'h0010_0000);
    send_item(CMD_STEP, 32'h0000_8000, '0, 32'h0010_0000);
    drain();

    load_config(DATA_MAX, DATA_MIN, DATA_MAX, 32'h0000_8000, 32'hFFFF_8000);
    send_item(CMD_STEP, 32'h0001_0000, '0, 32'h0100_0000);
    send_item(CMD_STEP, '0, 32'h0001_0000, 32'h0100_0000);
    send_item(CMD_STEP, '0, '0, '0);
    send_item(CMD_STEP, 32'd1, '0, 32'd1);
    send_item(CMD_STEP, DATA_MIN, DATA_MAX, 32'd1);
    send_item(CMD_CLEAR, '1, '1, '1);
    drain();

    load_config(32'h0002_0000, '0, DATA_MIN, 32'hFFFF_0000, 32'h0001_0000);
    send_item(CMD_STEP, 32'h0004_0000, '0, '0);
    send_item(CMD_STEP, '0, 32'h0004_0000, '0);
    send_item(CMD_STEP, '0, '0, '0);
    send_item(CMD_CLEAR, '0, '0, '0);
    drain();

    load_config(32'h0000_0100, 32'h0000_0001, '0, DATA_MAX, DATA_MIN);
    repeat (WINDUP_ITEMS) send_item(CMD_STEP, DATA_MAX, DATA_MIN, '1);

    for (int p = 0; p < PHASES; p++) begin
      drain();
      phase_config(p);
      set_idling(idle_mode_t'((p / 2) % 4));
      if (p == 1) hold_token <= hold_token + 1;
      repeat (PHASE_ITEMS) send_random();
    end
    drain();

    if (mismatches == 0 && pending == 0) begin
      $display("pid_controller_clamped_top_tb: PASS");
    end else begin
      $display("pid_controller_clamped_top_tb: FAIL");
    end
    $finish;
  end

endmodule
